FILE: rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, codes and types for the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Table depth and position width
    localparam int MAX_FRAMES = 64;
    localparam int POS_W      = $clog2(MAX_FRAMES);

    // Fixed field widths
    localparam int COUNT_W  = 7;    // frame_count register
    localparam int FRAME_W  = 16;   // table frame number, head index
    localparam int OUTF_W   = FRAME_W + 1;
    localparam int RAW_W    = 8;    // raw hold in 60 Hz ticks
    localparam int SCALE_W  = 13;   // Q5.8 speed scale
    localparam int DELTA_W  = 16;   // Q0.16 frame time
    localparam int OFFS_W   = 8;    // signed hold offset
    localparam int HOLD_W   = 7;    // final hold, 1..100
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Hold arithmetic
    localparam int TICK_HZ   = 60;
    localparam int HOLD_MAX  = 100;
    localparam int HOLD_SAT  = 1000;
    localparam int PROD_W    = RAW_W + SCALE_W;          // raw * scale
    localparam int NUM_W     = PROD_W + 8;               // raw * scale * 256
    localparam int DEN_W     = DELTA_W + $clog2(TICK_HZ); // 60 * delta
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int STEP_W    = $clog2(HOLD_SAT + 1);
    localparam int SUM_W     = STEP_W + 2;               // signed step + offset

    // Operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Play modes
    localparam logic [1:0] MODE_HOLD  = 2'd0;
    localparam logic [1:0] MODE_ONCE  = 2'd1;
    localparam logic [1:0] MODE_CYCLE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_INDEX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_STEPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_OFFSET   = 3'd7;

    // Request into the hold calculator
    typedef struct packed {
        logic [RAW_W-1:0]          raw;
        logic [SCALE_W-1:0]        scale;
        logic [DELTA_W-1:0]        delta;
        logic signed [OFFS_W-1:0]  offset;
    } hold_req_t;

    // Status back from the hold calculator
    typedef struct packed {
        logic              done;
        logic [HOLD_W-1:0] hold;
    } hold_stat_t;

endpackage

FILE: rtl/sfs_hold_calc.sv
// ----------------------------------------------------------------------------
// sfs_hold_calc
// Hold length: floor(raw*scale*256 / (60*delta)), sat 1000, at least 1,
// plus signed offset, clamped to 1..100. One shared subtractor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfs_hold_calc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sfs_pkg::hold_req_t req,
    output sfs_pkg::hold_stat_t stat
);
    import sfs_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_DIV  = 3'b010,
        C_FIN  = 3'b100
    } calc_state_t;

    calc_state_t state_reg, state_next;

    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [NUM_W-1:0]         num_reg;      // numerator, shifts into quotient
    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     zero_reg;     // delta of zero: saturate
    logic signed [OFFS_W-1:0] offset_reg;
    logic [HOLD_W-1:0]        hold_reg;

    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           rem_diff;
    logic                     ge;
    logic [PROD_W-1:0]        prod;
    logic [DEN_W-1:0]         den_in;

    logic                     sat;
    logic [STEP_W-1:0]        step;
    logic signed [SUM_W-1:0]  sum;
    logic [HOLD_W-1:0]        hold_fin;

    // Divider step
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = rem_sh >= {1'b0, den_reg};

    assign prod   = PROD_W'(req.raw) * PROD_W'(req.scale);
    assign den_in = DEN_W'(req.delta) * DEN_W'(TICK_HZ);

    // Final clamp
    always_comb
    begin
        sat = zero_reg || (num_reg >= NUM_W'(HOLD_SAT));
        if (sat)
        begin
            step = STEP_W'(HOLD_SAT);
        end
        else if (num_reg[STEP_W-1:0] == '0)
        begin
            step = STEP_W'(1);
        end
        else
        begin
            step = num_reg[STEP_W-1:0];
        end
        sum = $signed({2'b00, step}) + SUM_W'(offset_reg);
        if (sum < SUM_W'(1))
        begin
            hold_fin = HOLD_W'(1);
        end
        else if (sum > SUM_W'(HOLD_MAX))
        begin
            hold_fin = HOLD_W'(HOLD_MAX);
        end
        else
        begin
            hold_fin = sum[HOLD_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = DIV_CNT_W'(NUM_W - 1);
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = C_FIN;
                end
            end
            C_FIN:
            begin
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            num_reg    <= {prod, 8'b0};
            den_reg    <= den_in;
            rem_reg    <= '0;
            zero_reg   <= (req.delta == '0);
            offset_reg <= req.offset;
        end
        else if (state_reg == C_DIV)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
        if (state_reg == C_FIN)
        begin
            hold_reg <= hold_fin;
        end
    end

    assign stat.done = done_reg;
    assign stat.hold = hold_reg;

endmodule

FILE: rtl/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Animation frame sequencer. Requests on the input channel (in_valid/in_stall)
// are loads into the frame and hold tables, restarts, or ticks. Every request
// returns exactly one result on the output channel (out_valid/out_stall):
// the global frame number at the current position, the last-frame and stopped
// flags, and the hold length of the current frame.
// A request that needs a new hold (a restart, or a tick that moves or wraps
// the position) waits for the 29-step restoring divider in sfs_hold_calc;
// other requests only go through the frame table read. One request is in
// flight at a time; the next one is taken the cycle after its result enters
// the output register, even if that result is still stalled. A stalled
// result holds in the output register; the sequencer waits with its next
// result until the register is free. Reset clears position, tick count and
// flags, sets the hold to 1 and loads the register defaults. Table contents
// are undefined until loaded. Configuration writes are taken on cfg_write;
// the user must write only while no request is open; nothing checks it.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write port
    input  logic                            cfg_write,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [5:0]                      entry_index,
    input  logic [sfs_pkg::FRAME_W-1:0]     entry_frame,
    input  logic [sfs_pkg::RAW_W-1:0]       entry_step,
    input  logic [sfs_pkg::DELTA_W-1:0]     delta_time,

    // Result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sfs_pkg::OUTF_W-1:0]      frame_number,
    output logic                            last_frame,
    output logic                            stopped,
    output logic [sfs_pkg::HOLD_W-1:0]      hold_ticks
);
    import sfs_pkg::*;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,   // waiting for a request
        ST_HREAD = 6'b000010,   // hold table read in flight
        ST_START = 6'b000100,   // kick the hold calculator
        ST_CALC  = 6'b001000,   // wait for the new hold
        ST_FREAD = 6'b010000,   // frame table read in flight
        ST_OUT   = 6'b100000    // hand the result to the output register
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration registers
    logic [COUNT_W-1:0]         frame_count_reg;
    logic [1:0]                 play_mode_reg;
    logic                       reverse_order_reg;
    logic [FRAME_W-1:0]         head_index_reg;
    logic                       manual_steps_reg;
    logic [RAW_W-1:0]           default_step_reg;
    logic [SCALE_W-1:0]         speed_scale_reg;
    logic signed [OFFS_W-1:0]   step_offset_reg;

    // Sequence state
    logic [HOLD_W-1:0]          tick_count_reg,   tick_count_next;
    logic [POS_W-1:0]           position_reg,     position_next;
    logic [HOLD_W-1:0]          current_hold_reg, current_hold_next;
    logic                       last_flag_reg,    last_flag_next;
    logic                       stop_flag_reg,    stop_flag_next;
    logic [DELTA_W-1:0]         delta_reg;

    // Tables, read every cycle at the slot of the current position
    logic [FRAME_W-1:0]         frame_mem [MAX_FRAMES];
    logic [RAW_W-1:0]           hold_mem  [MAX_FRAMES];
    logic [FRAME_W-1:0]         frame_rd_reg;
    logic [RAW_W-1:0]           hold_rd_reg;
    logic                       mem_we;
    logic [POS_W-1:0]           wr_slot;
    logic [POS_W-1:0]           rd_slot;

    // Output register
    logic                       out_valid_reg;
    logic [OUTF_W-1:0]          frame_number_reg;
    logic                       last_frame_reg;
    logic                       stopped_reg;
    logic [HOLD_W-1:0]          hold_ticks_reg;
    logic                       out_load;

    // Control helpers
    logic                       in_accept;
    logic [POS_W-1:0]           last_pos;    // effective frame count - 1
    logic                       at_end;
    logic [HOLD_W:0]            tick_inc;
    logic                       hold_hit;

    logic                       calc_start;
    hold_req_t                  calc_req;
    hold_stat_t                 calc_stat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // frame_count of 0 acts as 1, above the table depth acts as the depth
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            last_pos = '0;
        end
        else if (32'(frame_count_reg) > MAX_FRAMES)
        begin
            last_pos = POS_W'(MAX_FRAMES - 1);
        end
        else
        begin
            last_pos = POS_W'(frame_count_reg - COUNT_W'(1));
        end
    end

    // Reversed order reads from the top, and there a position past the end reads slot 0
    always_comb
    begin
        if (!reverse_order_reg)
        begin
            rd_slot = position_reg;
        end
        else if (position_reg <= last_pos)
        begin
            rd_slot = last_pos - position_reg;
        end
        else
        begin
            rd_slot = '0;
        end
    end

    assign at_end   = (position_reg >= last_pos);
    assign tick_inc = {1'b0, tick_count_reg} + (HOLD_W+1)'(1);
    assign hold_hit = (tick_inc >= {1'b0, current_hold_reg});

    // Sequencer and state update
    always_comb
    begin
        state_next        = state_reg;
        tick_count_next   = tick_count_reg;
        position_next     = position_reg;
        current_hold_next = current_hold_reg;
        last_flag_next    = last_flag_reg;
        stop_flag_next    = stop_flag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FREAD;
                    case (operation)
                        OP_LOAD:
                        begin
                            state_next = ST_FREAD;
                        end
                        OP_RESTART:
                        begin
                            position_next   = '0;
                            tick_count_next = '0;
                            last_flag_next  = 1'b0;
                            stop_flag_next  = 1'b0;
                            state_next      = ST_HREAD;
                        end
                        OP_TICK:
                        begin
                            case (play_mode_reg)
                                MODE_ONCE:
                                begin
                                    // finished once-sequence ignores ticks
                                    if (!last_flag_reg)
                                    begin
                                        if (hold_hit)
                                        begin
                                            tick_count_next = '0;
                                            if (at_end)
                                            begin
                                                stop_flag_next = 1'b1;
                                                last_flag_next = 1'b1;
                                            end
                                            else
                                            begin
                                                position_next = position_reg + POS_W'(1);
                                                state_next    = ST_HREAD;
                                            end
                                        end
                                        else
                                        begin
                                            tick_count_next = tick_inc[HOLD_W-1:0];
                                        end
                                    end
                                end
                                MODE_CYCLE:
                                begin
                                    if (hold_hit)
                                    begin
                                        tick_count_next = '0;
                                        if (at_end)
                                        begin
                                            position_next  = '0;
                                            last_flag_next = 1'b1;
                                        end
                                        else
                                        begin
                                            position_next  = position_reg + POS_W'(1);
                                            last_flag_next = 1'b0;
                                        end
                                        state_next = ST_HREAD;
                                    end
                                    else
                                    begin
                                        tick_count_next = tick_inc[HOLD_W-1:0];
                                    end
                                end
                                default:
                                begin
                                    // hold mode (and the unused code): frozen
                                    state_next = ST_FREAD;
                                end
                            endcase
                        end
                        default:
                        begin
                            // unused operation code: state unchanged
                            state_next = ST_FREAD;
                        end
                    endcase
                end
            end
            ST_HREAD:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                // frame read data settled long ago, go straight to output
                if (calc_stat.done)
                begin
                    current_hold_next = calc_stat.hold;
                    state_next        = ST_OUT;
                end
            end
            ST_FREAD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tick_count_reg   <= '0;
            position_reg     <= '0;
            current_hold_reg <= HOLD_W'(1);
            last_flag_reg    <= 1'b0;
            stop_flag_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_count_reg   <= tick_count_next;
            position_reg     <= position_next;
            current_hold_reg <= current_hold_next;
            last_flag_reg    <= last_flag_next;
            stop_flag_reg    <= stop_flag_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= COUNT_W'(1);
            play_mode_reg     <= MODE_HOLD;
            reverse_order_reg <= 1'b0;
            head_index_reg    <= '0;
            manual_steps_reg  <= 1'b0;
            default_step_reg  <= RAW_W'(6);
            speed_scale_reg   <= SCALE_W'(256);
            step_offset_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_COUNT:   frame_count_reg   <= cfg_data[COUNT_W-1:0];
                CFG_PLAY_MODE:     play_mode_reg     <= cfg_data[1:0];
                CFG_REVERSE_ORDER: reverse_order_reg <= cfg_data[0];
                CFG_HEAD_INDEX:    head_index_reg    <= cfg_data[FRAME_W-1:0];
                CFG_MANUAL_STEPS:  manual_steps_reg  <= cfg_data[0];
                CFG_DEFAULT_STEP:  default_step_reg  <= cfg_data[RAW_W-1:0];
                CFG_SPEED_SCALE:   speed_scale_reg   <= cfg_data[SCALE_W-1:0];
                CFG_STEP_OFFSET:   step_offset_reg   <= $signed(cfg_data[OFFS_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // Tables: load writes at acceptance, slots past the depth are dropped
    assign mem_we  = in_accept && (operation == OP_LOAD) && (32'(entry_index) < MAX_FRAMES);
    assign wr_slot = POS_W'(entry_index);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_slot] <= entry_frame;
            hold_mem[wr_slot]  <= entry_step;
        end
        frame_rd_reg <= frame_mem[rd_slot];
        hold_rd_reg  <= hold_mem[rd_slot];
    end

    // Request delta kept for the hold computation
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            delta_reg <= delta_time;
        end
    end

    // Hold calculator
    assign calc_start      = (state_reg == ST_START);
    assign calc_req.raw    = manual_steps_reg ? hold_rd_reg : default_step_reg;
    assign calc_req.scale  = speed_scale_reg;
    assign calc_req.delta  = delta_reg;
    assign calc_req.offset = step_offset_reg;

    sfs_hold_calc u_hold_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .req   (calc_req),
        .stat  (calc_stat)
    );

    // Output register
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            frame_number_reg <= {1'b0, head_index_reg} + {1'b0, frame_rd_reg};
            last_frame_reg   <= last_flag_reg;
            stopped_reg      <= stop_flag_reg;
            hold_ticks_reg   <= current_hold_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_number = frame_number_reg;
    assign last_frame   = last_frame_reg;
    assign stopped      = stopped_reg;
    assign hold_ticks   = hold_ticks_reg;

`ifndef SYNTH
    // hold always stays in its legal range
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        (current_hold_reg >= HOLD_W'(1)) && (current_hold_reg <= HOLD_W'(HOLD_MAX)))
        else $error("current hold out of range");

    // tick count never reaches the hold of the current frame
    a_tick_below_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg < current_hold_reg)
        else $error("tick count reached hold");

    // a new result only comes from the output state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside output state");

    // the calculator only reports while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        calc_stat.done |-> (state_reg == ST_CALC))
        else $error("hold done outside wait state");
`endif

endmodule

FILE: verif/sfs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfs_checker
// Watches the register port and both channels of the sprite frame sequencer,
// keeps its own copy of the tables, play state and registers, predicts the
// one result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module sfs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [5:0]                      entry_index,
    input  logic [sfs_pkg::FRAME_W-1:0]     entry_frame,
    input  logic [sfs_pkg::RAW_W-1:0]       entry_step,
    input  logic [sfs_pkg::DELTA_W-1:0]     delta_time,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [sfs_pkg::OUTF_W-1:0]      frame_number,
    input  logic                            last_frame,
    input  logic                            stopped,
    input  logic [sfs_pkg::HOLD_W-1:0]      hold_ticks,
    output int                              mismatches,
    output int                              results_pending
);
    import sfs_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [OUTF_W-1:0] frame;
        logic              last;
        logic              stop;
        logic [HOLD_W-1:0] hold;
    } frame_result_t;

    // Predicted play state
    logic [FRAME_W-1:0] frame_tbl [MAX_FRAMES];
    logic [RAW_W-1:0]   hold_tbl  [MAX_FRAMES];
    logic [HOLD_W-1:0]  tick_cnt;
    logic [HOLD_W-1:0]  cur_hold;
    logic [POS_W-1:0]   pos;
    logic               last_f;
    logic               stop_f;

    // Register copies
    logic [COUNT_W-1:0]       frame_count_r;
    logic [1:0]               play_mode_r;
    logic                     reverse_r;
    logic [FRAME_W-1:0]       head_r;
    logic                     manual_r;
    logic [RAW_W-1:0]         default_step_r;
    logic [SCALE_W-1:0]       scale_r;
    logic signed [OFFS_W-1:0] offset_r;

    frame_result_t results_due [$];
    int            mismatch_count = 0;

    assign mismatches = mismatch_count;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("sfs_checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int active_frames();
        if (frame_count_r == 0)
            return 1;
        if (frame_count_r > MAX_FRAMES)
            return MAX_FRAMES;
        return int'(frame_count_r);
    endfunction

    // Reverse order reads from the top of the sequence; a position past the
    // sequence end reads slot 0 there.
    function automatic int table_slot(int p);
        int n;
        n = active_frames();
        if (!reverse_r)
            return p;
        return (p < n) ? n - 1 - p : 0;
    endfunction

    // floor(raw * scale * 256 / (60 * delta)), floored at 1, plus offset,
    // clamped to 1..100; zero delta saturates
    function automatic logic [HOLD_W-1:0] scaled_hold(int p, logic [DELTA_W-1:0] delta);
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        int ticks;
        num = manual_r ? 64'(hold_tbl[POS_W'(table_slot(p))]) : 64'(default_step_r);
        if (delta == 0) begin
            ticks = HOLD_SAT;
        end
        else begin
            num = num * 64'(scale_r) * 64'(256);
            den = 64'(delta);
            den = den * 64'(TICK_HZ);
            quo = num / den;
            ticks = (quo > HOLD_SAT) ? HOLD_SAT : int'(quo);
        end
        if (ticks < 1)
            ticks = 1;
        ticks = ticks + offset_r;
        if (ticks < 1)
            ticks = 1;
        if (ticks > HOLD_MAX)
            ticks = HOLD_MAX;
        return HOLD_W'(ticks);
    endfunction

    function automatic void advance_tick(logic [DELTA_W-1:0] delta);
        int n;
        n = active_frames();
        if (play_mode_r == MODE_ONCE) begin
            if (last_f)
                return;
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= cur_hold) begin
                tick_cnt = '0;
                if (int'(pos) >= n - 1) begin
                    stop_f = 1'b1;
                    last_f = 1'b1;
                end
                else begin
                    pos      = pos + 1'b1;
                    cur_hold = scaled_hold(int'(pos), delta);
                end
            end
        end
        else if (play_mode_r == MODE_CYCLE) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= cur_hold) begin
                tick_cnt = '0;
                if (int'(pos) >= n - 1) begin
                    pos    = '0;
                    last_f = 1'b1;
                end
                else begin
                    pos    = pos + 1'b1;
                    last_f = 1'b0;
                end
                cur_hold = scaled_hold(int'(pos), delta);
            end
        end
    endfunction

    function automatic frame_result_t sequence_step(logic [1:0] op, logic [5:0] slot,
                                                    logic [FRAME_W-1:0] frame,
                                                    logic [RAW_W-1:0] raw,
                                                    logic [DELTA_W-1:0] delta);
        frame_result_t r;
        case (op)
            OP_LOAD: begin
                frame_tbl[slot] = frame;
                hold_tbl[slot]  = raw;
            end
            OP_RESTART: begin
                pos      = '0;
                tick_cnt = '0;
                last_f   = 1'b0;
                stop_f   = 1'b0;
                cur_hold = scaled_hold(0, delta);
            end
            OP_TICK: advance_tick(delta);
            default: ;
        endcase
        r.frame = {1'b0, head_r} + {1'b0, frame_tbl[POS_W'(table_slot(int'(pos)))]};
        r.last  = last_f;
        r.stop  = stop_f;
        r.hold  = cur_hold;
        return r;
    endfunction

    function automatic void write_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_FRAME_COUNT:   frame_count_r  = value[COUNT_W-1:0];
            CFG_PLAY_MODE:     play_mode_r    = value[1:0];
            CFG_REVERSE_ORDER: reverse_r      = value[0];
            CFG_HEAD_INDEX:    head_r         = value[FRAME_W-1:0];
            CFG_MANUAL_STEPS:  manual_r       = value[0];
            CFG_DEFAULT_STEP:  default_step_r = value[RAW_W-1:0];
            CFG_SPEED_SCALE:   scale_r        = value[SCALE_W-1:0];
            CFG_STEP_OFFSET:   offset_r       = value[OFFS_W-1:0];
            default: ;
        endcase
    endfunction

    // Results are compared before the new request is predicted: a result can
    // never belong to a request taken at the same edge.
    always @(posedge clk or negedge rst_n) begin
        frame_result_t want;
        if (!rst_n) begin
            tick_cnt       = '0;
            pos            = '0;
            cur_hold       = HOLD_W'(1);
            last_f         = 1'b0;
            stop_f         = 1'b0;
            frame_count_r  = COUNT_W'(1);
            play_mode_r    = MODE_HOLD;
            reverse_r      = 1'b0;
            head_r         = '0;
            manual_r       = 1'b0;
            default_step_r = RAW_W'(6);
            scale_r        = SCALE_W'(256);
            offset_r       = '0;
            results_due.delete();
        end
        else begin
            if (cfg_write)
                write_setting(cfg_index, cfg_data);
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no request outstanding, frame_number",
                                    32'(frame_number), 32'(0));
                end
                else begin
                    want = results_due.pop_front();
                    if (frame_number !== want.frame)
                        report_mismatch("frame_number", 32'(frame_number), 32'(want.frame));
                    if (last_frame !== want.last)
                        report_mismatch("last_frame", 32'(last_frame), 32'(want.last));
                    if (stopped !== want.stop)
                        report_mismatch("stopped", 32'(stopped), 32'(want.stop));
                    if (hold_ticks !== want.hold)
                        report_mismatch("hold_ticks", 32'(hold_ticks), 32'(want.hold));
                end
            end
            if (in_valid && !in_stall)
                results_due.push_back(sequence_step(operation, entry_index, entry_frame,
                                                    entry_step, delta_time));
        end
        results_pending = results_due.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the sprite frame sequencer testbench. Fills both tables, runs short
// directed phases over the register extremes and the odd cases (zero frame
// time, frame count out of range, spare play mode and operation, positions
// past the sequence end), then random phases under changing idle patterns.
// Prediction and checking live in sfs_checker; this module makes stimulus,
// watches for a hang and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
    import sfs_pkg::*;

    // Codes the package does not name: both are spare and must be ignored
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int SETTLE_CYCLES   = 40;    // a hold calculation plus margin
    localparam int HOLDOFF_CYCLES  = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no transfer on either channel
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_REQUESTS  = 90;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             operation = OP_LOAD;
    logic [5:0]             entry_index = '0;
    logic [FRAME_W-1:0]     entry_frame = '0;
    logic [RAW_W-1:0]       entry_step = '0;
    logic [DELTA_W-1:0]     delta_time = '0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [OUTF_W-1:0]      frame_number;
    logic                   last_frame;
    logic                   stopped;
    logic [HOLD_W-1:0]      hold_ticks;

    int                     mismatches;
    int                     results_pending;

    // Idle pattern, in percent per cycle; written by the stimulus process
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;

    // Long hold-off handshake: stimulus bumps the ask count, the receiver
    // process notices and counts the hold-off out on its own
    int                     holdoff_asked = 0;
    int                     holdoff_served = 0;
    int                     holdoff_left = 0;

    int                     quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sprite_frame_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .entry_index  (entry_index),
        .entry_frame  (entry_frame),
        .entry_step   (entry_step),
        .delta_time   (delta_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_number (frame_number),
        .last_frame   (last_frame),
        .stopped      (stopped),
        .hold_ticks   (hold_ticks)
    );

    sfs_checker sequence_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .entry_index     (entry_index),
        .entry_frame     (entry_frame),
        .entry_step      (entry_step),
        .delta_time      (delta_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_number    (frame_number),
        .last_frame      (last_frame),
        .stopped         (stopped),
        .hold_ticks      (hold_ticks),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // Receiver: random stalls at the falling edge, or a long hold-off when
    // asked. During the hold-off the sequencer fills and stalls its input.
    always @(negedge clk)
    begin
        if (holdoff_left > 0) begin
            out_stall    <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end
        else if (holdoff_served != holdoff_asked) begin
            holdoff_served = holdoff_asked;
            holdoff_left   = HOLDOFF_CYCLES;
            out_stall      <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Hang detector: cycles in which neither channel moves a request
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one request at a falling edge, after a random idle gap, and hold
    // it until taken. Valid stays high on return so back-to-back requests
    // never see valid dropped and raised in the same step.
    task automatic offer_request(logic [1:0] op, int slot, int frame, int raw, int delta);
        @(negedge clk);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= 6'(slot);
        entry_frame <= FRAME_W'(frame);
        entry_step  <= RAW_W'(raw);
        delta_time  <= DELTA_W'(delta);
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // Quiet point between phases: no request open, none in flight
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Writes all eight registers on consecutive edges; write enable stays
    // high through the burst and drops once at the end.
    task automatic load_settings(int count, logic [1:0] mode, int rev, int head, int manual,
                                 int dstep, int scale, int offset);
        logic [CFG_IDX_W-1:0] idx [8];
        int                   value [8];
        idx   = '{CFG_FRAME_COUNT, CFG_PLAY_MODE, CFG_REVERSE_ORDER, CFG_HEAD_INDEX,
                  CFG_MANUAL_STEPS, CFG_DEFAULT_STEP, CFG_SPEED_SCALE, CFG_STEP_OFFSET};
        value = '{count, int'(mode), rev, head, manual, dstep, scale, offset & 8'hFF};
        for (int i = 0; i < 8; i++) begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= CFG_DATA_W'(value[i]);
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random settings lean toward short holds and short sequences so that
    // positions advance, stop and wrap often; extremes come up now and then.
    task automatic load_random_settings();
        int         count;
        int         offset;
        int         scale;
        int         dstep;
        int         pick;
        logic [1:0] mode;
        pick = $urandom_range(9);
        case (pick)
            0:       count = 0;
            1:       count = $urandom_range(127, 65);
            2:       count = MAX_FRAMES;
            3, 4, 5: count = $urandom_range(4, 1);
            default: count = $urandom_range(MAX_FRAMES, 1);
        endcase
        pick = $urandom_range(9);
        if (pick < 5)
            offset = 0;
        else if (pick < 8)
            offset = int'($urandom_range(20)) - 10;
        else if (pick < 9)
            offset = int'($urandom_range(255)) - 128;
        else
            offset = -int'($urandom_range(100));
        pick = $urandom_range(9);
        if (pick < 5)
            scale = 256;
        else if (pick < 8)
            scale = $urandom_range(4096, 1);
        else if (pick < 9)
            scale = $urandom_range(8191, 4097);
        else
            scale = $urandom_range(1);
        dstep = ($urandom_range(9) < 7) ? $urandom_range(12) : $urandom_range(255);
        pick = $urandom_range(9);
        if (pick < 4)
            mode = MODE_ONCE;
        else if (pick < 8)
            mode = MODE_CYCLE;
        else if (pick < 9)
            mode = MODE_HOLD;
        else
            mode = MODE_SPARE;
        load_settings(count, mode, $urandom_range(1), $urandom_range(65535), $urandom_range(1),
                      dstep, scale, offset);
    endtask

    // Mostly ticks; restarts keep once-mode sequences alive; loads rewrite
    // slots (all slots are already written); a few spare operations.
    task automatic offer_random_request();
        int         pick;
        int         delta;
        int         raw;
        logic [1:0] op;
        pick = $urandom_range(99);
        if (pick < 62)
            op = OP_TICK;
        else if (pick < 74)
            op = OP_RESTART;
        else if (pick < 95)
            op = OP_LOAD;
        else
            op = OP_NONE;
        pick = $urandom_range(99);
        if (pick < 3)
            delta = 0;
        else if (pick < 15)
            delta = $urandom_range(65535);
        else if (pick < 25)
            delta = $urandom_range(1200, 1);
        else
            delta = $urandom_range(65535, 4000);
        raw = ($urandom_range(9) < 6) ? $urandom_range(8) : $urandom_range(255);
        offer_request(op, $urandom_range(63), $urandom_range(65535), raw, delta);
    endtask

    initial
    begin
        int raw;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Fill every slot first: a read of a never-loaded slot is not allowed.
        // Slot 0 is read from the first result on, so it goes first.
        set_idling(11, 11);
        offer_request(OP_LOAD, 0, 16'hFFFF, 255, $urandom_range(65535));
        offer_request(OP_LOAD, 1, 0, 0, $urandom_range(65535));
        for (int i = 2; i < MAX_FRAMES; i++) begin
            raw = ($urandom_range(9) < 7) ? $urandom_range(6) : $urandom_range(255);
            offer_request(OP_LOAD, i, $urandom_range(65535), raw, $urandom_range(65535));
        end

        // Play once over three frames with every hold forced to one tick:
        // runs to the end, stops, then ignores ticks and the spare operation
        settle_block();
        load_settings(3, MODE_ONCE, 0, 16'hFFFF, 1, 6, 256, -128);
        offer_request(OP_RESTART, 0, 0, 0, 65535);
        repeat (4) offer_request(OP_TICK, 0, 0, 0, 65535);
        offer_request(OP_NONE, 9, 16'h5A5A, 77, 300);
        offer_request(OP_LOAD, 5, 16'h8001, 3, 16'h8000);

        // Frame count above the table depth, reversed, zero and tiny frame
        // time (both saturate), largest scale and offset
        settle_block();
        load_settings(127, MODE_CYCLE, 1, 0, 0, 255, 8191, 127);
        offer_request(OP_RESTART, 0, 0, 0, 0);
        offer_request(OP_RESTART, 0, 0, 0, 1);
        repeat (2) offer_request(OP_TICK, 0, 0, 0, 0);

        // Frame count zero, spare play mode, zero raw hold and zero scale
        settle_block();
        load_settings(0, MODE_SPARE, 1, 1, 0, 0, 0, 100);
        offer_request(OP_RESTART, 0, 0, 0, 1);
        repeat (2) offer_request(OP_TICK, 0, 0, 0, 2);

        // Walk a long sequence forward to leave the position deep
        settle_block();
        load_settings(64, MODE_CYCLE, 0, 12345, 1, 1, 4096, -100);
        offer_request(OP_RESTART, 0, 0, 0, 65535);
        repeat (6) offer_request(OP_TICK, 0, 0, 0, 65535);

        // Shrink the sequence under that position: reversed it reads slot 0,
        // and the next step wraps
        settle_block();
        load_settings(4, MODE_CYCLE, 1, 7, 0, 1, 256, 0);
        repeat (3) offer_request(OP_TICK, 0, 0, 0, 40000);

        // Random phases over the four idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle_block();
            load_random_settings();
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(78, 0);
                2:       set_idling(0, 78);
                default: set_idling(11, 11);
            endcase
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                // long receiver hold-off while requests keep coming
                if (p == 0 && k == 10)
                    holdoff_asked = holdoff_asked + 1;
                // sender pause until everything outstanding has returned
                if (p == 1 && k == 40)
                    drain_results();
                offer_random_request();
            end
        end

        settle_block();
        if (mismatches == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sfs_pkg.sv
rtl/sfs_hold_calc.sv
rtl/sprite_frame_sequencer.sv
verif/sfs_checker.sv
verif/tb.sv
